>>> rtl/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg - shared types and constants of the serial command deframer
// Item structs, command and event codes, framing characters and the
// command-to-frame-length decode.
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic       download_active;
	} in_item_t;

	typedef struct packed {
		logic        event_res;
		logic [7:0]  frame_command;
		logic [55:0] payload;
		logic [2:0]  payload_len;
	} out_item_t;

	localparam logic [1:0] CMD_BYTE     = 2'd0;
	localparam logic [1:0] CMD_TICK     = 2'd1;
	localparam logic [1:0] CMD_LINE_ERR = 2'd2;

	localparam logic EV_FRAME      = 1'b0;
	localparam logic EV_NEXT_BLOCK = 1'b1;

	localparam logic [7:0] START_BYTE      = 8'h2A;
	localparam logic [7:0] NEXT_BLOCK_BYTE = 8'h23;
	localparam logic [7:0] CHAR_LOWER_Y    = 8'h79;
	localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [7:0] CHAR_COLON      = 8'h3A;

	localparam logic [15:0] TIMEOUT_RESET = 16'd504;

	// longest frame accepted; lengths above it are dropped at the command byte
	localparam int MAX_FRAME_BYTES = 10;
	// longest length the decode can produce
	localparam logic [3:0] FRAME_LEN_MAX = 4'd10;

	function automatic logic [3:0] frame_length(input logic [7:0] c);
		logic [3:0] len;
		if (c >= CHAR_LOWER_Y) begin
			len = 4'd5;
		end else if (c >= CHAR_LOWER_A) begin
			len = 4'd4;
		end else if (c >= CHAR_UPPER_A) begin
			len = 4'd3;
		end else if (c >= CHAR_COLON) begin
			len = 4'd9;
		end else begin
			len = 4'd10;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/scd_frame.sv
// ---------------------------------------------------------------------------
// scd_frame - frame state and single-pass step logic
// Holds the partial frame, running XOR and timeout counter; on each go
// strobe applies one item and reports at most one result.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_frame
	import scd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire in_item_t    item,
	input  wire logic [15:0] timeout_ticks,
	output logic             res_valid,
	output out_item_t        res
);

	logic [3:0]  byte_count_q,   byte_count_n;
	logic [3:0]  expected_len_q, expected_len_n;
	logic [7:0]  running_xor_q,  running_xor_n;
	logic [7:0]  held_command_q, held_command_n;
	logic [55:0] payload_q,      payload_n;
	logic [15:0] timeout_left_q, timeout_left_n;

	always_comb begin
		logic [3:0] pos;
		logic [4:0] count_inc;
		logic [7:0] xor_inc;
		logic [3:0] len;
		logic [2:0] idx;

		byte_count_n   = byte_count_q;
		expected_len_n = expected_len_q;
		running_xor_n  = running_xor_q;
		held_command_n = held_command_q;
		payload_n      = payload_q;
		timeout_left_n = timeout_left_q;
		res_valid      = 1'b0;
		res            = '0;
		pos            = byte_count_q;
		count_inc      = {1'b0, byte_count_q} + 5'd1;
		xor_inc        = running_xor_q ^ item.rx_byte;
		len            = frame_length(item.rx_byte);
		idx            = 3'(byte_count_q - 4'd2);

		if (go) begin
			unique case (item.command)
				CMD_TICK: begin
					if (timeout_left_q != 16'd0) begin
						timeout_left_n = timeout_left_q - 16'd1;
					end
				end
				CMD_LINE_ERR: begin
					byte_count_n   = '0;
					expected_len_n = '0;
					running_xor_n  = '0;
					held_command_n = '0;
					payload_n      = '0;
				end
				CMD_BYTE: begin
					// expired partial frame
					if (byte_count_q != 4'd0 && timeout_left_q == 16'd0) begin
						byte_count_n   = '0;
						expected_len_n = '0;
						running_xor_n  = '0;
						held_command_n = '0;
						payload_n      = '0;
					end
					pos       = byte_count_n;
					count_inc = {1'b0, byte_count_n} + 5'd1;
					xor_inc   = running_xor_n ^ item.rx_byte;
					idx       = 3'(byte_count_n - 4'd2);

					if (item.download_active && item.rx_byte == NEXT_BLOCK_BYTE) begin
						res_valid     = 1'b1;
						res.event_res = EV_NEXT_BLOCK;
					end else if (pos == 4'd0) begin
						if (item.rx_byte == START_BYTE) begin
							byte_count_n   = 4'd1;
							expected_len_n = '0;
							running_xor_n  = item.rx_byte;
							held_command_n = '0;
							payload_n      = '0;
							timeout_left_n = timeout_ticks;
						end
					end else if (pos == 4'd1) begin
						if ({1'b0, len} > 5'(MAX_FRAME_BYTES)) begin
							byte_count_n   = '0;
							expected_len_n = '0;
							running_xor_n  = '0;
							held_command_n = '0;
							payload_n      = '0;
						end else begin
							byte_count_n   = 4'(count_inc);
							running_xor_n  = xor_inc;
							held_command_n = item.rx_byte;
							expected_len_n = len;
						end
					end else begin
						if (count_inc < {1'b0, expected_len_n} && pos >= 4'd2
						    && (pos - 4'd2) < 4'd7) begin
							payload_n[{idx, 3'b000} +: 8] =
								payload_n[{idx, 3'b000} +: 8] | item.rx_byte;
						end
						if (count_inc >= {1'b0, expected_len_n}) begin
							if (xor_inc == 8'd0) begin
								res_valid         = 1'b1;
								res.event_res     = EV_FRAME;
								res.frame_command = held_command_n;
								res.payload       = payload_n;
								res.payload_len   = 3'(expected_len_n - 4'd3);
							end
							byte_count_n   = '0;
							expected_len_n = '0;
							running_xor_n  = '0;
							held_command_n = '0;
							payload_n      = '0;
						end else begin
							byte_count_n  = 4'(count_inc);
							running_xor_n = xor_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			expected_len_q <= '0;
			running_xor_q  <= '0;
			held_command_q <= '0;
			payload_q      <= '0;
			timeout_left_q <= '0;
		end else begin
			byte_count_q   <= byte_count_n;
			expected_len_q <= expected_len_n;
			running_xor_q  <= running_xor_n;
			held_command_q <= held_command_n;
			payload_q      <= payload_n;
			timeout_left_q <= timeout_left_n;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= FRAME_LEN_MAX)
		else $error("frame byte count beyond longest frame");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q == 4'd0 |-> running_xor_q == 8'd0 && payload_q == 56'd0)
		else $error("idle with stale frame state");

	a_len_known: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q >= 4'd2 |-> expected_len_q >= 4'd3 && byte_count_q < expected_len_q)
		else $error("frame length not decoded or overrun");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> !res_valid)
		else $error("result without a request");

endmodule

`default_nettype wire

>>> rtl/serial_command_deframer.sv
// ---------------------------------------------------------------------------
// serial_command_deframer - start byte / XOR checksum frame parser
//
// Input channel (in_valid, in_stall, in_item): one request per received
// byte, 1 ms tick or line error. Output channel (out_valid, out_stall,
// out_item): a checked frame, or a next-block request while a download is
// active. Config channel (cfg_valid, cfg_ready, cfg_data): timeout in ticks,
// always ready; the user must write it only while the block is idle, as the
// block does not enforce this. A request is registered on acceptance and is
// processed once the output register can advance; its result, if any, is
// registered there. One request per cycle is sustained unless the receiver
// stalls: a single-pass step between the input and output registers. When
// the receiver stalls, the output register holds and the input register
// fills; in_stall rises only while both are occupied and out_stall is high.
// Reset clears the frame state, empties both registers and loads the
// timeout with 504 ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_command_deframer
	import scd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic [15:0] timeout_ticks_q;
	logic        adv;
	logic        go;
	logic        res_valid;
	out_item_t   res;

	assign adv       = !out_valid_q || !out_stall;
	assign go        = valid_s1 && adv;
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= go && res_valid;
			end
			if (cfg_valid && cfg_ready) begin
				timeout_ticks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (go && res_valid) begin
			out_item_q <= res;
		end
	end

	scd_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.item          (item_s1),
		.timeout_ticks (timeout_ticks_q),
		.res_valid     (res_valid),
		.res           (res)
	);

endmodule

`default_nettype wire

>>> verif/serial_command_deframer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// serial_command_deframer_test - self-checking bench for the frame parser
// A short table of directed requests is followed by random traffic: mostly
// framed commands with random content, with noise, cut frames, ticks, line
// errors and next-block bytes mixed in. A predictor built into the bench
// tracks the frame state. Each delivered result is compared field by field
// with the oldest prediction. The timeout is rewritten between phases, with
// both ends of its range. Both sides idle and stall at random until phase 4.
// ---------------------------------------------------------------------------

module serial_command_deframer_test;
	import scd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int STUCK_LIMIT = 2000;
	localparam int PHASE_ITEMS = 300;
	localparam out_item_t NO_EV = '0;

	typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		in_item_t    item;
		logic        has_ev;
		out_item_t   ev;
		logic [15:0] tmo;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// predicted frame state
	logic [3:0]  frm_count = '0;
	logic [3:0]  frm_len = '0;
	logic [7:0]  frm_xor = '0;
	logic [7:0]  frm_cmd = '0;
	logic [55:0] frm_data = '0;
	logic [15:0] ticks_left = '0;
	logic [15:0] tmo_cfg = TIMEOUT_RESET;

	out_item_t   due_events[$];
	in_item_t    burst[$];
	row_t        tab[$];

	logic        row_typed = 1'b0;
	logic        row_has = 1'b0;
	out_item_t   row_ev = '0;

	int          send_idle = 28;
	int          recv_stall = 70;
	int          live_items = 0;
	int          errors = 0;
	int          stuck = 0;

	serial_command_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall);
	end

	task automatic mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic void clear_frame();
		frm_count = '0;
		frm_len = '0;
		frm_xor = '0;
		frm_cmd = '0;
		frm_data = '0;
	endfunction

	function automatic logic deframe(input in_item_t it, output out_item_t ev);
		int   pos;
		logic hit;
		ev = NO_EV;
		live_items++;
		if (it.command == CMD_TICK) begin
			if (ticks_left != 0) begin
				ticks_left = ticks_left - 16'd1;
			end
			return 1'b0;
		end
		if (it.command == CMD_LINE_ERR) begin
			clear_frame();
			return 1'b0;
		end
		if (it.command != CMD_BYTE) begin
			return 1'b0;
		end
		if (frm_count != 0 && ticks_left == 0) begin
			clear_frame();
		end
		if (it.download_active && it.rx_byte == NEXT_BLOCK_BYTE) begin
			ev.event_res = EV_NEXT_BLOCK;
			return 1'b1;
		end
		if (frm_count == 0) begin
			if (it.rx_byte == START_BYTE) begin
				frm_count = 4'd1;
				frm_xor = START_BYTE;
				ticks_left = tmo_cfg;
			end
			return 1'b0;
		end
		pos = frm_count;
		frm_count = frm_count + 4'd1;
		frm_xor = frm_xor ^ it.rx_byte;
		if (pos == 1) begin
			frm_cmd = it.rx_byte;
			if (it.rx_byte < CHAR_COLON) begin
				frm_len = 4'd10;
			end else if (it.rx_byte < CHAR_UPPER_A) begin
				frm_len = 4'd9;
			end else if (it.rx_byte < CHAR_LOWER_A) begin
				frm_len = 4'd3;
			end else if (it.rx_byte < CHAR_LOWER_Y) begin
				frm_len = 4'd4;
			end else begin
				frm_len = 4'd5;
			end
			if (frm_len > MAX_FRAME_BYTES) begin
				clear_frame();
			end
			return 1'b0;
		end
		if (pos + 1 < frm_len && pos - 2 < 7) begin
			frm_data[8 * (pos - 2) +: 8] = it.rx_byte;
		end
		if (frm_count >= frm_len) begin
			hit = (frm_xor == 8'd0);
			ev = {EV_FRAME, frm_cmd, frm_data, 3'(frm_len - 4'd3)};
			clear_frame();
			return hit;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		out_item_t ev;
		logic      hit;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (due_events.size() == 0) begin
					mismatch($sformatf("unexpected result %h", out_item));
				end else begin
					want = due_events.pop_front();
					if (out_item.event_res !== want.event_res)
						mismatch($sformatf("event %b, want %b",
							out_item.event_res, want.event_res));
					if (out_item.frame_command !== want.frame_command)
						mismatch($sformatf("command %h, want %h",
							out_item.frame_command, want.frame_command));
					if (out_item.payload !== want.payload)
						mismatch($sformatf("payload %h, want %h",
							out_item.payload, want.payload));
					if (out_item.payload_len !== want.payload_len)
						mismatch($sformatf("payload_len %0d, want %0d",
							out_item.payload_len, want.payload_len));
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				hit = deframe(in_item, ev);
				if (row_typed) begin
					if (row_has) begin
						due_events.push_back(row_ev);
					end
				end else if (hit) begin
					due_events.push_back(ev);
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				tmo_cfg = cfg_data;
			end
			if (moved) begin
				stuck = 0;
			end else begin
				stuck++;
				if (stuck >= STUCK_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	function automatic in_item_t req_item(input logic [1:0] c, input logic [7:0] b,
			input logic dl);
		in_item_t it;
		it.command = c;
		it.rx_byte = b;
		it.download_active = dl;
		return it;
	endfunction

	function automatic row_t row(input row_kind_t k, input logic [1:0] c,
			input logic [7:0] b, input logic dl, input logic has, input out_item_t ev,
			input logic [15:0] tmo);
		row_t r;
		r.kind = k;
		r.item = req_item(c, b, dl);
		r.has_ev = has;
		r.ev = ev;
		r.tmo = tmo;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(input in_item_t it, input logic typed, input logic has,
			input out_item_t ev);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_has = has;
		row_ev = ev;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_burst();
		logic [7:0] fb [10];
		int         n;
		int         cut;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			case ($urandom_range(0, 4))
			0: begin
				n = 5;
				fb[1] = 8'($urandom_range(CHAR_LOWER_Y, 255));
			end
			1: begin
				n = 4;
				fb[1] = 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Y - 1));
			end
			2: begin
				n = 3;
				fb[1] = 8'($urandom_range(CHAR_UPPER_A, CHAR_LOWER_A - 1));
			end
			3: begin
				n = 9;
				fb[1] = 8'($urandom_range(CHAR_COLON, CHAR_UPPER_A - 1));
			end
			default: begin
				n = 10;
				fb[1] = 8'($urandom_range(0, CHAR_COLON - 1));
			end
			endcase
			fb[0] = START_BYTE;
			for (int i = 2; i < n - 1; i++) fb[i] = 8'($urandom);
			fb[n - 1] = 8'd0;
			for (int i = 0; i < n - 1; i++) fb[n - 1] = fb[n - 1] ^ fb[i];
			if ($urandom_range(0, 9) == 0) fb[n - 1] = fb[n - 1] ^ 8'($urandom_range(1, 255));
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
			for (int i = 0; i < cut; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 3))
						burst.push_back(req_item(CMD_TICK, 8'($urandom), 1'($urandom)));
				end
				if ($urandom_range(0, 39) == 0)
					burst.push_back(req_item(CMD_BYTE, NEXT_BLOCK_BYTE, 1'b1));
				if ($urandom_range(0, 59) == 0)
					burst.push_back(req_item(CMD_LINE_ERR, 8'($urandom), 1'($urandom)));
				burst.push_back(req_item(CMD_BYTE, fb[i], $urandom_range(0, 4) == 0));
			end
		end else if (r < 82) begin
			burst.push_back(req_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom)));
		end else if (r < 90) begin
			burst.push_back(req_item(CMD_BYTE, NEXT_BLOCK_BYTE, $urandom_range(0, 3) != 0));
		end else begin
			repeat ($urandom_range(1, 12))
				burst.push_back(req_item(CMD_TICK, 8'($urandom), 1'($urandom)));
		end
	endtask

	initial begin
		int          goal;
		logic [15:0] tmo;

		// idle bytes, unused code, tick while idle
		tab.push_back(row(ROW_TYPED, CMD_BYTE, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_UNUSED, 8'hFF, 1'b1, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_TICK, 8'hFF, 1'b1, 1'b0, NO_EV, 16'd0));
		// shortest frame
		tab.push_back(row(ROW_TYPED, CMD_BYTE, START_BYTE, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, CHAR_UPPER_A, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, 8'h6B, 1'b0, 1'b1,
			{EV_FRAME, CHAR_UPPER_A, 56'd0, 3'd0}, 16'd0));
		// longest frame, tick and next-block byte inside it
		tab.push_back(row(ROW_PRED, CMD_BYTE, START_BYTE, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_PRED, CMD_BYTE, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_TICK, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));
		repeat (4) tab.push_back(row(ROW_PRED, CMD_BYTE, 8'hFF, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, NEXT_BLOCK_BYTE, 1'b1, 1'b1,
			{EV_NEXT_BLOCK, 8'd0, 56'd0, 3'd0}, 16'd0));
		repeat (3) tab.push_back(row(ROW_PRED, CMD_BYTE, 8'hFF, 1'b1, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, 8'hD5, 1'b0, 1'b1,
			{EV_FRAME, 8'h00, {56{1'b1}}, 3'd7}, 16'd0));
		// line error drops a partial frame
		tab.push_back(row(ROW_PRED, CMD_BYTE, START_BYTE, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_LINE_ERR, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));
		// expiry restarts on the next start byte, then a bad check byte
		tab.push_back(row(ROW_CFG, CMD_BYTE, 8'h00, 1'b0, 1'b0, NO_EV, 16'd1));
		tab.push_back(row(ROW_PRED, CMD_BYTE, START_BYTE, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_PRED, CMD_TICK, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, START_BYTE, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_PRED, CMD_BYTE, CHAR_UPPER_A, 1'b0, 1'b0, NO_EV, 16'd0));
		tab.push_back(row(ROW_TYPED, CMD_BYTE, 8'h00, 1'b0, 1'b0, NO_EV, 16'd0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (tab[i]) begin
			if (tab[i].kind == ROW_CFG) begin
				drain();
				set_timeout(tab[i].tmo);
			end else begin
				send(tab[i].item, tab[i].kind == ROW_TYPED, tab[i].has_ev, tab[i].ev);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: tmo = 16'hFFFF;
			1: tmo = 16'($urandom_range(2, 12));
			2: tmo = 16'd0;
			3: tmo = 16'($urandom_range(1, 12));
			4: tmo = TIMEOUT_RESET;
			default: tmo = 16'($urandom_range(2, 40));
			endcase
			drain();
			set_timeout(tmo);
			send_idle = (ph < 2) ? 28 : (ph < 4) ? 70 : 0;
			recv_stall = (ph < 2) ? 70 : (ph < 4) ? 28 : 0;
			goal = live_items + PHASE_ITEMS;
			while (live_items < goal) begin
				make_burst();
				while (burst.size() != 0) send(burst.pop_front(), 1'b0, 1'b0, NO_EV);
			end
		end

		drain();
		if (due_events.size() != 0)
			mismatch($sformatf("%0d results never arrived", due_events.size()));
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
